>>> rtl/core/sfrc_pkg.sv
package sfrc_pkg;

    // Frame parser phases
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN     = 3'd1,
        PH_SRC     = 3'd2,
        PH_HDR     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CSUM    = 3'd5
    } phase_t;

    // Header codes of host replies
    localparam logic [7:0] HDR_ACK = 8'd0;
    localparam logic [7:0] HDR_NAK = 8'd5;

    // Frame status codes
    localparam logic [2:0] ST_ACK    = 3'd0;
    localparam logic [2:0] ST_NAK    = 3'd1;
    localparam logic [2:0] ST_OTHER  = 3'd2;
    localparam logic [2:0] ST_BADSUM = 3'd3;
    localparam logic [2:0] ST_DEVICE = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ADDR   = 2'd0;
    localparam logic [1:0] CFG_HOST_ADDR     = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_ACKS = 2'd2;

    // Register reset values
    localparam logic [7:0] DEVICE_ADDR_RST   = 8'd40;
    localparam logic [7:0] HOST_ADDR_RST     = 8'd1;
    localparam logic [7:0] EXPECTED_ACKS_RST = 8'd9;

    localparam logic [7:0] ACK_MAX = 8'hFF;

endpackage

>>> rtl/core/serial_frame_receiver_checksum.sv
// Serial frame receiver with 8-bit additive checksum.
// Input channel: one received byte (rx_byte) per transaction, in_valid/in_stall.
// The block hunts for a byte equal to device_addr or host_addr, then parses
// destination, length, source, header, payload bytes and the checksum byte.
// Output channel: one transaction per finished frame (on the checksum byte),
// carrying frame_status, header_code, payload_len, ack_total and all_acked.
// Every other byte produces no output transaction.
// Throughput: one byte per cycle while in_stall is low; the per-byte parser
// update is a single 8-bit add and compare between the state registers and
// the output register. The result is registered and appears on out_valid in
// the cycle after the checksum byte is accepted.
// When the output is stalled with a result pending, in_stall is raised in the
// same cycle, so no byte is taken until the result leaves; the held result
// does not change. A result that is taken in a cycle frees the input at once.
// Reset (rst_n low, asynchronous) puts the parser in hunting, clears the
// ACK counter and done flag, and loads the configuration reset values.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered on clk.
module serial_frame_receiver_checksum
    import sfrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration write port
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] frame_status,
    output logic [7:0] header_code,
    output logic [7:0] payload_len,
    output logic [7:0] ack_total,
    output logic       all_acked
);

    logic [7:0] device_addr_reg;
    logic [7:0] host_addr_reg;
    logic [7:0] expected_acks_reg;

    phase_t     phase_reg,       phase_next;
    logic [7:0] bytes_left_reg,  bytes_left_next;
    logic [7:0] sum_reg,         sum_next;
    logic       to_host_reg,     to_host_next;
    logic [7:0] length_reg,      length_next;
    logic [7:0] header_reg,      header_next;
    logic [7:0] ack_cnt_reg,     ack_cnt_next;
    logic       done_reg,        done_next;

    logic       out_valid_reg,   out_valid_next;
    logic [2:0] status_reg,      status_next;
    logic [7:0] hdr_out_reg,     hdr_out_next;
    logic [7:0] len_out_reg,     len_out_next;
    logic [7:0] ack_out_reg,     ack_out_next;
    logic       done_out_reg,    done_out_next;

    logic       in_accept;
    logic       out_taken;
    logic [7:0] sum_add;
    logic       addr_hit;
    logic [7:0] ack_inc;

    // Handshake
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_taken = out_valid_reg && !out_stall;

    assign sum_add  = sum_reg + rx_byte;
    assign addr_hit = (rx_byte == host_addr_reg) || (rx_byte == device_addr_reg);
    assign ack_inc  = (ack_cnt_reg != ACK_MAX) ? ack_cnt_reg + 8'd1 : ack_cnt_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_addr_reg   <= DEVICE_ADDR_RST;
            host_addr_reg     <= HOST_ADDR_RST;
            expected_acks_reg <= EXPECTED_ACKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEVICE_ADDR:   device_addr_reg   <= cfg_data;
                CFG_HOST_ADDR:     host_addr_reg     <= cfg_data;
                CFG_EXPECTED_ACKS: expected_acks_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_accept)
        begin
            unique case (phase_reg)
                PH_LEN:     phase_next = PH_SRC;
                PH_SRC:     phase_next = PH_HDR;
                PH_HDR:     phase_next = (bytes_left_reg == 8'd0) ? PH_CSUM : PH_PAYLOAD;
                PH_PAYLOAD: phase_next = (bytes_left_reg == 8'd1) ? PH_CSUM : PH_PAYLOAD;
                PH_CSUM:    phase_next = PH_HUNT;
                default:    phase_next = addr_hit ? PH_LEN : PH_HUNT;
            endcase
        end
    end

    // Frame datapath and result
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;
        to_host_next    = to_host_reg;
        length_next     = length_reg;
        header_next     = header_reg;
        ack_cnt_next    = ack_cnt_reg;
        done_next       = done_reg;

        out_valid_next  = out_taken ? 1'b0 : out_valid_reg;
        status_next     = status_reg;
        hdr_out_next    = hdr_out_reg;
        len_out_next    = len_out_reg;
        ack_out_next    = ack_out_reg;
        done_out_next   = done_out_reg;

        if (in_accept)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    length_next     = rx_byte;
                    bytes_left_next = rx_byte;
                    sum_next        = sum_add;
                end
                PH_SRC:
                begin
                    sum_next = sum_add;
                end
                PH_HDR:
                begin
                    header_next = rx_byte;
                    sum_next    = sum_add;
                end
                PH_PAYLOAD:
                begin
                    sum_next        = sum_add;
                    bytes_left_next = bytes_left_reg - 8'd1;
                end
                PH_CSUM:
                begin
                    sum_next = sum_add;
                    priority if (sum_add != 8'd0)
                        status_next = ST_BADSUM;
                    else if (!to_host_reg)
                        status_next = ST_DEVICE;
                    else if (header_reg == HDR_ACK)
                    begin
                        status_next  = ST_ACK;
                        ack_cnt_next = ack_inc;
                        if (ack_inc == expected_acks_reg)
                            done_next = 1'b1;
                    end
                    else if (header_reg == HDR_NAK)
                        status_next = ST_NAK;
                    else
                        status_next = ST_OTHER;
                    out_valid_next = 1'b1;
                    hdr_out_next   = header_reg;
                    len_out_next   = length_reg;
                    ack_out_next   = ack_cnt_next;
                    done_out_next  = done_next;
                end
                default:
                begin
                    // hunting: a matching address byte opens a frame
                    if (addr_hit)
                    begin
                        to_host_next    = (rx_byte == host_addr_reg);
                        sum_next        = rx_byte;
                        bytes_left_next = 8'd0;
                    end
                end
            endcase
        end
    end

    // State and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= 8'd0;
            sum_reg        <= 8'd0;
            to_host_reg    <= 1'b0;
            length_reg     <= 8'd0;
            header_reg     <= 8'd0;
            ack_cnt_reg    <= 8'd0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            sum_reg        <= sum_next;
            to_host_reg    <= to_host_next;
            length_reg     <= length_next;
            header_reg     <= header_next;
            ack_cnt_reg    <= ack_cnt_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        hdr_out_reg  <= hdr_out_next;
        len_out_reg  <= len_out_next;
        ack_out_reg  <= ack_out_next;
        done_out_reg <= done_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = status_reg;
    assign header_code  = hdr_out_reg;
    assign payload_len  = len_out_reg;
    assign ack_total    = ack_out_reg;
    assign all_acked    = done_out_reg;

endmodule
